// ----- src/ptir_pkg.sv -----
// Package of the peer table insert/replace unit: field widths, status and
// register codes, and the record and command types shared by the cell row.
// Depends on nothing.
`default_nettype none
package ptir_pkg;

  localparam int unsigned Entries  = 32;
  localparam int unsigned IdW      = 64;
  localparam int unsigned MagicW   = 32;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned SigW     = 8;
  localparam int unsigned CountW   = 32;
  localparam int unsigned SlotOutW = 5;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned UsedOutW = 6;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [StatusW-1:0] {
    ST_BAD_MAGIC = 3'd0,
    ST_OWN_ID    = 3'd1,
    ST_UPDATED   = 3'd2,
    ST_NEW       = 3'd3,
    ST_REPLACED  = 3'd4,
    ST_MARKED    = 3'd5,
    ST_UNUSED    = 3'd6
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OWN_ID    = 1'b0,
    REG_EXP_MAGIC = 1'b1
  } cfg_reg_e;

  // Search record handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [CountW-1:0] count;
    logic [TimeW-1:0]  first;
    logic [TimeW-1:0]  oldest;
  } rec_t;

  // Search key broadcast to every cell while a record travels.
  typedef struct packed {
    logic                mark;
    logic [IdW-1:0]      key;
    logic [SlotOutW-1:0] ss;
  } srch_t;

  // Write command broadcast to every cell; the addressed cell takes it.
  typedef struct packed {
    logic              wr_entry;
    logic              wr_stale;
    logic [IdW-1:0]    id;
    logic [TimeW-1:0]  first;
    logic [TimeW-1:0]  last;
    logic [SigW-1:0]   sig;
    logic [CountW-1:0] count;
  } cmd_t;

endpackage
`default_nettype wire

// ----- src/ptir_if.sv -----
// Handshake interfaces of the peer table insert/replace unit: request
// channel and result channel. Depends on ptir_pkg.
`default_nettype none
interface ptir_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [ptir_pkg::IdW-1:0]      peer_id;
  logic [ptir_pkg::MagicW-1:0]   report_magic;
  logic [ptir_pkg::TimeW-1:0]    report_time;
  logic [ptir_pkg::SigW-1:0]     link_signal;
  logic [ptir_pkg::SlotOutW-1:0] stale_slot;

  modport source (output valid, req_type, peer_id, report_magic, report_time,
                  link_signal, stale_slot, input ready);
  modport sink (input valid, req_type, peer_id, report_magic, report_time,
                link_signal, stale_slot, output ready);
endinterface

interface ptir_out_if;
  logic                          valid;
  logic                          ready;
  logic [ptir_pkg::StatusW-1:0]  status;
  logic [ptir_pkg::SlotOutW-1:0] slot;
  logic [ptir_pkg::CountW-1:0]   encounters;
  logic [ptir_pkg::TimeW-1:0]    first_seen;
  logic [ptir_pkg::CountW-1:0]   total_seen;
  logic [ptir_pkg::UsedOutW-1:0] entries_used;

  modport source (output valid, status, slot, encounters, first_seen, total_seen,
                  entries_used, input ready);
  modport sink (input valid, status, slot, encounters, first_seen, total_seen,
                entries_used, output ready);
endinterface
`default_nettype wire

// ----- src/ptir_cell.sv -----
// One table slot of the peer table, with its stage of the search chain.
// Depends on ptir_pkg.
`default_nettype none
module ptir_cell #(
  parameter int unsigned ENTRIES = ptir_pkg::Entries,
  parameter int unsigned IDX     = 0,
  localparam int unsigned SlotW  = $clog2(ENTRIES),
  localparam int unsigned UsedW  = $clog2(ENTRIES + 1)
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  ptir_pkg::srch_t      srch_i,
  input  wire [UsedW-1:0]      used_i,
  input  ptir_pkg::rec_t       rec_i,
  input  wire [SlotW-1:0]      fslot_i,
  input  wire [SlotW-1:0]      vslot_i,
  output ptir_pkg::rec_t       rec_o,
  output logic [SlotW-1:0]     fslot_o,
  output logic [SlotW-1:0]     vslot_o,
  input  ptir_pkg::cmd_t       cmd_i,
  input  wire [SlotW-1:0]      wr_slot_i
);

  localparam logic [SlotW-1:0]              IdxSlot = SlotW'(IDX);
  localparam logic [UsedW-1:0]              IdxUsed = UsedW'(IDX);
  localparam logic [ptir_pkg::SlotOutW-1:0] IdxSs   = ptir_pkg::SlotOutW'(IDX);
  localparam bit                            IdxFits = IDX < (1 << ptir_pkg::SlotOutW);

  logic [ptir_pkg::IdW-1:0]    id_q;
  logic [ptir_pkg::TimeW-1:0]  first_q;
  logic [ptir_pkg::TimeW-1:0]  last_q;
  logic [ptir_pkg::SigW-1:0]   sig_q;
  logic [ptir_pkg::CountW-1:0] count_q;
  logic                        stale_q;

  ptir_pkg::rec_t   rec_d, rec_q;
  logic [SlotW-1:0] fslot_d, fslot_q, vslot_d, vslot_q;
  logic             hit, addr_hit;

  // In a report search a used slot hits on its identifier; in a mark search
  // the slot named by the request hits.
  always_comb begin
    if (srch_i.mark) begin
      hit = IdxFits && (srch_i.ss == IdxSs);
    end else begin
      hit = (IdxUsed < used_i) && (id_q == srch_i.key);
    end
  end

  always_comb begin
    rec_d   = rec_i;
    fslot_d = fslot_i;
    vslot_d = vslot_i;
    if (hit && !rec_i.found) begin
      rec_d.found = 1'b1;
      rec_d.count = count_q;
      rec_d.first = first_q;
      fslot_d     = IdxSlot;
    end
    // Strict compare keeps the lowest slot on a tie.
    if (stale_q && (last_q < rec_i.oldest)) begin
      rec_d.oldest = last_q;
      vslot_d      = IdxSlot;
    end
  end

  assign addr_hit = (wr_slot_i == IdxSlot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q   <= '0;
      fslot_q <= '0;
      vslot_q <= '0;
      stale_q <= 1'b0;
    end else begin
      rec_q   <= rec_d;
      fslot_q <= fslot_d;
      vslot_q <= vslot_d;
      if (addr_hit && cmd_i.wr_entry) begin
        stale_q <= 1'b0;
      end else if (addr_hit && cmd_i.wr_stale) begin
        stale_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (addr_hit && cmd_i.wr_entry) begin
      id_q    <= cmd_i.id;
      first_q <= cmd_i.first;
      last_q  <= cmd_i.last;
      sig_q   <= cmd_i.sig;
      count_q <= cmd_i.count;
    end
  end

  assign rec_o   = rec_q;
  assign fslot_o = fslot_q;
  assign vslot_o = vslot_q;

  // The signal strength is stored for the entry but has no read path.
  logic sig_unused;
  assign sig_unused = ^sig_q;

endmodule
`default_nettype wire

// ----- src/peer_table_insert_replace_unit.sv -----
// Top level of the peer table insert/replace unit: request control, the
// row of table cells and the result register.
// Depends on ptir_pkg, ptir_if (ptir_in_if, ptir_out_if) and ptir_cell.
`default_nettype none
// The unit keeps a table of ENTRIES peers keyed by a 64-bit identifier. A
// health report with the wrong magic word, or carrying this node's own
// identifier, is dropped with a status and changes nothing. Any other report
// updates the matching entry, or fills the next free slot, or, when the
// table is full, reuses the stale entry with the oldest last-seen time
// (slot 0 when no stale entry qualifies). A mark-stale request flags one
// used slot as stale. Every request gives exactly one result transfer.
// Each slot lives in its own cell; a search record enters the first cell and
// moves one cell per clock, collecting the match and the oldest stale entry
// on the way. A new request is taken only once the previous one has been
// written and the unit is idle again. A finished result waits in its output
// register while the next request is already taken and searched.
// Configuration (own_id at index 0, expected_magic at index 1) is written
// through cfg_we_i while the unit is idle; the user is bound to this, and the
// unit itself does not enforce it. No clearing pass is needed after reset.
module peer_table_insert_replace_unit #(
  parameter int unsigned ENTRIES = ptir_pkg::Entries
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [ptir_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [ptir_pkg::CfgDataW-1:0]  cfg_data_i,
  ptir_in_if.sink                       in_i,
  ptir_out_if.source                    out_o
);

  localparam int unsigned SlotW  = $clog2(ENTRIES);
  localparam int unsigned UsedW  = $clog2(ENTRIES + 1);
  localparam int unsigned SlotOW = ptir_pkg::SlotOutW;
  localparam int unsigned UsedOW = ptir_pkg::UsedOutW;
  localparam int unsigned MagW   = ptir_pkg::MagicW;
  localparam logic [UsedW-1:0] Full = UsedW'(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_WRITE  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [ptir_pkg::IdW-1:0]  own_id_q;
  logic [MagW-1:0]           magic_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q <= '0;
      magic_q  <= '0;
    end else if (cfg_we_i) begin
      case (ptir_pkg::cfg_reg_e'(cfg_idx_i))
        ptir_pkg::REG_OWN_ID:    own_id_q <= cfg_data_i;
        ptir_pkg::REG_EXP_MAGIC: magic_q  <= cfg_data_i[MagW-1:0];
        default: ;
      endcase
    end
  end

  // Request held for the whole search and write.
  logic                          req_mark_q;
  logic [ptir_pkg::IdW-1:0]      req_id_q;
  logic [MagW-1:0]               req_magic_q;
  logic [ptir_pkg::TimeW-1:0]    req_time_q;
  logic [ptir_pkg::SigW-1:0]     req_sig_q;
  logic [ptir_pkg::SlotOutW-1:0] req_ss_q;

  logic in_xfer, out_xfer, out_free;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_mark_q  <= in_i.req_type;
      req_id_q    <= in_i.peer_id;
      req_magic_q <= in_i.report_magic;
      req_time_q  <= in_i.report_time;
      req_sig_q   <= in_i.link_signal;
      req_ss_q    <= in_i.stale_slot;
    end
  end

  // Cell row. Link i feeds cell i; the last link is the chain tail.
  ptir_pkg::rec_t   rec_c   [ENTRIES+1];
  logic [SlotW-1:0] fslot_c [ENTRIES+1];
  logic [SlotW-1:0] vslot_c [ENTRIES+1];
  ptir_pkg::srch_t  srch;
  ptir_pkg::cmd_t   cmd;
  logic [SlotW-1:0] wr_slot;
  logic             start_q;
  logic [UsedW-1:0] used_q, used_d;
  logic [ptir_pkg::CountW-1:0] total_q, total_d;

  assign srch.mark = req_mark_q;
  assign srch.key  = req_id_q;
  assign srch.ss   = req_ss_q;

  always_comb begin
    rec_c[0]        = '0;
    rec_c[0].valid  = start_q;
    rec_c[0].oldest = '1;
    fslot_c[0]      = '0;
    vslot_c[0]      = '0;
  end

  for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
    ptir_cell #(
      .ENTRIES (ENTRIES),
      .IDX     (gi)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .srch_i    (srch),
      .used_i    (used_q),
      .rec_i     (rec_c[gi]),
      .fslot_i   (fslot_c[gi]),
      .vslot_i   (vslot_c[gi]),
      .rec_o     (rec_c[gi+1]),
      .fslot_o   (fslot_c[gi+1]),
      .vslot_o   (vslot_c[gi+1]),
      .cmd_i     (cmd),
      .wr_slot_i (wr_slot)
    );
  end

  // Search outcome captured from the chain tail.
  logic                        h_found_q;
  logic [SlotW-1:0]            h_fslot_q, h_vslot_q;
  logic [ptir_pkg::CountW-1:0] h_count_q;
  logic [ptir_pkg::TimeW-1:0]  h_first_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_SEARCH && rec_c[ENTRIES].valid) begin
      h_found_q <= rec_c[ENTRIES].found;
      h_fslot_q <= fslot_c[ENTRIES];
      h_vslot_q <= vslot_c[ENTRIES];
      h_count_q <= rec_c[ENTRIES].count;
      h_first_q <= rec_c[ENTRIES].first;
    end
  end

  // Decision and write-back, taken in the write state once the output
  // register is free.
  ptir_pkg::status_e           res_status;
  logic [SlotW-1:0]            res_slot;
  logic                        res_slot_zero;
  logic [ptir_pkg::CountW-1:0] res_count;
  logic [ptir_pkg::TimeW-1:0]  res_first;
  logic                        commit;

  assign out_free = !out_o.valid || out_o.ready;
  assign commit   = (state_q == S_WRITE) && out_free;

  always_comb begin
    res_status    = ptir_pkg::ST_UNUSED;
    res_slot      = '0;
    res_slot_zero = 1'b1;
    res_count     = '0;
    res_first     = '0;
    used_d        = used_q;
    total_d       = total_q;
    cmd           = '0;
    cmd.id        = req_id_q;
    cmd.last      = req_time_q;
    cmd.sig       = req_sig_q;
    if (req_mark_q) begin
      if (int'(req_ss_q) < int'(used_q)) begin
        res_status    = ptir_pkg::ST_MARKED;
        res_slot      = SlotW'(req_ss_q);
        res_slot_zero = 1'b0;
        res_count     = h_count_q;
        res_first     = h_first_q;
        cmd.wr_stale  = commit;
      end
    end else if (req_magic_q != magic_q) begin
      res_status = ptir_pkg::ST_BAD_MAGIC;
    end else if (req_id_q == own_id_q) begin
      res_status = ptir_pkg::ST_OWN_ID;
    end else begin
      res_slot_zero = 1'b0;
      total_d       = total_q + 1'b1;
      if (h_found_q) begin
        res_status = ptir_pkg::ST_UPDATED;
        res_slot   = h_fslot_q;
        res_count  = h_count_q + 1'b1;
        res_first  = (h_first_q == '0) ? req_time_q : h_first_q;
      end else begin
        // A fresh or reused entry restarts its history with this report.
        res_count = ptir_pkg::CountW'(1);
        res_first = req_time_q;
        if (used_q == Full) begin
          res_status = ptir_pkg::ST_REPLACED;
          res_slot   = h_vslot_q;
        end else begin
          res_status = ptir_pkg::ST_NEW;
          res_slot   = used_q[SlotW-1:0];
          used_d     = used_q + 1'b1;
        end
      end
      cmd.wr_entry = commit;
      cmd.first    = res_first;
      cmd.count    = res_count;
    end
  end

  assign wr_slot = res_slot;

  // Control state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_xfer) state_d = S_SEARCH;
      S_SEARCH: if (rec_c[ENTRIES].valid) state_d = S_WRITE;
      S_WRITE:  if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      used_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_xfer;
      if (commit) begin
        used_q      <= used_d;
        total_q     <= total_d;
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  logic [ptir_pkg::StatusW-1:0] o_status_q;
  logic [SlotOW-1:0]            o_slot_q;
  logic [ptir_pkg::CountW-1:0]  o_enc_q, o_total_q;
  logic [ptir_pkg::TimeW-1:0]   o_first_q;
  logic [UsedOW-1:0]            o_used_q;

  always_ff @(posedge clk_i) begin
    if (commit) begin
      o_status_q <= res_status;
      o_slot_q   <= res_slot_zero ? '0 : SlotOW'(res_slot);
      o_enc_q    <= res_count;
      o_first_q  <= res_first;
      o_total_q  <= total_d;
      o_used_q   <= UsedOW'(used_d);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = o_status_q;
  assign out_o.slot         = o_slot_q;
  assign out_o.encounters   = o_enc_q;
  assign out_o.first_seen   = o_first_q;
  assign out_o.total_seen   = o_total_q;
  assign out_o.entries_used = o_used_q;

  // The tail's oldest time has served its purpose once the victim slot is known.
  logic tail_unused;
  assign tail_unused = ^rec_c[ENTRIES].oldest;

  // A search record is only launched on entry to the search state.
  a_start_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> state_q == S_SEARCH)
    else $error("search launched outside the search state");

  // The record leaves the cell row only while the search is pending.
  a_tail_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_c[ENTRIES].valid |-> state_q == S_SEARCH)
    else $error("search record arrived while no search was pending");

  // The fill count never passes the table size.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= Full)
    else $error("fill count beyond table size");

  // The fill count moves only in a write step, and by one.
  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q != $past(used_q) |-> $past(state_q) == S_WRITE && used_q == $past(used_q) + 1'b1)
    else $error("fill count changed outside a write step");

  // A result appears only after a write step.
  a_result_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_WRITE)
    else $error("result raised without a write step");

endmodule
`default_nettype wire
